// ===== rtl/core/kbc_pkg.sv =====
// package for the kbc command byte sequencer
// holds step, phase, op and status codes plus field widths; no dependencies
package kbc_pkg;

    localparam int unsigned POLL_LIMIT_MAX      = 65535;
    localparam int unsigned DRAIN_LIMIT_MAX     = 256;
    localparam int unsigned STABLE_ATTEMPTS_MAX = 8;

    localparam logic [7:0]  CMD_READ_BYTE  = 8'h20;
    localparam logic [7:0]  CMD_WRITE_BYTE = 8'h60;
    localparam logic [63:0] GEN_LIMIT      = 64'hFFFF_FFFF_FFFF_FFFE;

    localparam logic [2:0] PH_EMPTY    = 3'd0;
    localparam logic [2:0] PH_PREPARED = 3'd1;
    localparam logic [2:0] PH_ACTIVE   = 3'd2;
    localparam logic [2:0] PH_QUIESCED = 3'd3;
    localparam logic [2:0] PH_POISONED = 3'd4;

    localparam logic [2:0] OP_PREPARE = 3'd0;
    localparam logic [2:0] OP_PUBLISH = 3'd1;
    localparam logic [2:0] OP_ABORT   = 3'd2;
    localparam logic [2:0] OP_QUIESCE = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;
    localparam logic [2:0] OP_RETIRE  = 3'd5;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_BAD_ARG  = 4'd1;
    localparam logic [3:0] ST_BAD_STATE = 4'd2;
    localparam logic [3:0] ST_IDENTITY = 4'd3;
    localparam logic [3:0] ST_POISONED = 4'd4;
    localparam logic [3:0] ST_TIMEOUT  = 4'd5;
    localparam logic [3:0] ST_IO       = 4'd6;
    localparam logic [3:0] ST_UNAVAIL  = 4'd7;
    localparam logic [3:0] ST_EXHAUSTED = 4'd8;

    localparam logic [1:0] K_READ   = 2'd0;
    localparam logic [1:0] K_WRITE  = 2'd1;
    localparam logic [1:0] K_FINISH = 2'd2;

    localparam logic [2:0] CFG_OWNER  = 3'd0;
    localparam logic [2:0] CFG_POLL   = 3'd1;
    localparam logic [2:0] CFG_DRAIN  = 3'd2;
    localparam logic [2:0] CFG_STABLE = 3'd3;
    localparam logic [2:0] CFG_DATA   = 3'd4;
    localparam logic [2:0] CFG_STATUS = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE       = 5'd0,
        S_DRAIN_STAT = 5'd1,
        S_DRAIN_DATA = 5'd2,
        S_RD_WIN     = 5'd3,
        S_RD_CMD     = 5'd4,
        S_RD_OUT     = 5'd5,
        S_RD_DATA    = 5'd6,
        S_W_WIN1     = 5'd7,
        S_W_CMD      = 5'd8,
        S_W_WIN2     = 5'd9,
        S_W_DATA     = 5'd10,
        S_VF_WIN     = 5'd11,
        S_VF_CMD     = 5'd12,
        S_VF_OUT     = 5'd13,
        S_VF_DATA    = 5'd14
    } t_step;

    typedef struct packed {
        logic [31:0] owner;
        logic [15:0] poll_cap;
        logic [8:0]  drain_cap;
        logic [3:0]  stable_attempts;
        logic [15:0] data_addr;
        logic [15:0] stat_addr;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port;
        logic [7:0]  wbyte;
        logic [3:0]  status;
        logic [2:0]  phase;
        logic        mutated;
    } t_result;

endpackage

// ===== rtl/core/kbc_cfg_regs.sv =====
// configuration register file for the kbc sequencer
// depends on kbc_pkg for register indexes and the t_cfg struct
module kbc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output kbc_pkg::t_cfg       o_cfg
);
    import kbc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWNER:  r_cfg.owner           <= i_cfg_data;
                CFG_POLL:   r_cfg.poll_cap        <= i_cfg_data[15:0];
                CFG_DRAIN:  r_cfg.drain_cap       <= i_cfg_data[8:0];
                CFG_STABLE: r_cfg.stable_attempts <= i_cfg_data[3:0];
                CFG_DATA:   r_cfg.data_addr       <= i_cfg_data[15:0];
                CFG_STATUS: r_cfg.stat_addr       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/kbc_command_byte_sequencer.sv =====
// kbc command byte sequencer top level
// depends on kbc_pkg and kbc_cfg_regs
//
// usage: a slave stream carries requests (tuser=0) and bus completions
// (tuser=1); a master stream carries one result per acting item: a bus read,
// a bus write or an operation-finished report. requests while a sequence
// runs and completions while idle are consumed without a result.
// each item is decoded combinationally from the registered sequencer state
// and the result lands in an output register; one item per cycle sustained
// while the skid stage is empty. the output register and a skid stage let a
// new item be taken while a result still waits, so a stalled receiver only
// blocks input once both hold a result. the live configuration comes from a
// plain write port, written only while idle: the user must keep to this, the block does not enforce it.
// reset (synchronous, active low) clears phase, bytes, counters, generation
// and all configuration registers to zero; the step goes idle.
module kbc_command_byte_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] op_code, [34:3] caller_identity, [42:35] bus_data, [44:43] bus_result
    input  logic [47:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] out_kind, [17:2] port_addr, [25:18] write_byte, [29:26] op_status,
    // [32:30] phase_now, [33] mutated_flag
    output logic [39:0] m_axis_tdata
);
    import kbc_pkg::*;

    t_cfg cfg;
    kbc_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    logic [2:0]  in_op;
    logic [31:0] in_caller;
    logic [7:0]  d;
    logic [1:0]  in_res;
    assign in_op     = s_axis_tdata[2:0];
    assign in_caller = s_axis_tdata[34:3];
    assign d         = s_axis_tdata[42:35];
    assign in_res    = s_axis_tdata[44:43];

    t_step       r_step, n_step;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_orig, n_orig, r_staged, n_staged, r_active, n_active;
    logic        r_mut, n_mut;
    logic [63:0] r_gen, n_gen;
    logic [15:0] r_poll, n_poll;
    logic [8:0]  r_drain, n_drain;
    logic [3:0]  r_att, n_att;
    logic [7:0]  r_prev, n_prev, r_target, n_target;
    logic [2:0]  r_pend, n_pend;
    logic        r_inw, n_inw;

    // output register plus skid stage
    logic    r_ov, r_sv;
    t_result r_ob, r_sb;
    t_result res;
    logic    emit_ok;

    logic accept;
    assign s_axis_tready = !r_sv;
    assign accept = s_axis_tvalid && s_axis_tready;

    // combinational sequencer step
    always_comb begin
        logic [1:0]  k;
        logic [15:0] p;
        logic [7:0]  wb;
        logic [3:0]  st;
        logic        fin;
        logic        fl;
        logic [3:0]  fst;
        logic [3:0]  bst;
        logic        vf;
        logic        dodrain;
        logic        dostable;
        logic        dowrite;
        logic [7:0]  wval;
        logic        winpoll;
        t_step       wstep;
        logic        outpoll;
        logic        stnext;
        logic [2:0]  need;
        logic [7:0]  sb;
        logic [15:0] pc;

        n_step = r_step; n_phase = r_phase; n_orig = r_orig; n_staged = r_staged;
        n_active = r_active; n_mut = r_mut; n_gen = r_gen; n_poll = r_poll;
        n_drain = r_drain; n_att = r_att; n_prev = r_prev; n_target = r_target;
        n_pend = r_pend; n_inw = r_inw;
        k = K_FINISH; p = '0; wb = '0; st = ST_OK; fin = 1'b0;
        fl = 1'b0; fst = ST_OK; emit_ok = 1'b0;
        dodrain = 1'b0; dostable = 1'b0; dowrite = 1'b0; wval = '0;
        winpoll = 1'b0; wstep = S_IDLE; outpoll = 1'b0; stnext = 1'b0;
        need = PH_EMPTY; sb = '0; pc = r_poll;
        vf = (r_step >= S_VF_WIN);
        bst = (in_res == 2'd0) ? ST_OK : ((in_res == 2'd2) ? ST_UNAVAIL : ST_IO);

        if (!s_axis_tuser) begin
            if (r_step == S_IDLE) begin
                emit_ok = 1'b1;
                n_pend = in_op;
                n_inw = 1'b0;
                if (in_op > OP_RETIRE) begin
                    fin = 1'b1; st = ST_BAD_ARG;
                end else if (in_op == OP_PREPARE) begin
                    if (cfg.owner == 32'd0 || cfg.owner == 32'hFFFF_FFFF ||
                        cfg.poll_cap == 16'd0 ||
                        cfg.drain_cap == 9'd0 ||
                        cfg.drain_cap > 9'(DRAIN_LIMIT_MAX) ||
                        cfg.stable_attempts < 4'd2 ||
                        cfg.stable_attempts > 4'(STABLE_ATTEMPTS_MAX) ||
                        cfg.data_addr == 16'd0 || cfg.stat_addr == 16'd0 ||
                        cfg.data_addr == cfg.stat_addr) begin
                        fin = 1'b1; st = ST_BAD_ARG;
                    end else if (r_phase == PH_POISONED) begin
                        fin = 1'b1; st = ST_POISONED;
                    end else if (r_phase != PH_EMPTY) begin
                        fin = 1'b1; st = ST_BAD_STATE;
                    end else if (r_gen >= GEN_LIMIT) begin
                        fin = 1'b1; st = ST_EXHAUSTED;
                    end else begin
                        n_gen = r_gen + 64'd1;
                        n_drain = '0;
                        dodrain = 1'b1;
                    end
                end else begin
                    need = (in_op == OP_PUBLISH || in_op == OP_ABORT) ? PH_PREPARED :
                           ((in_op == OP_QUIESCE) ? PH_ACTIVE : PH_QUIESCED);
                    if (in_caller == 32'd0 || in_caller == 32'hFFFF_FFFF) begin
                        fin = 1'b1; st = ST_BAD_ARG;
                    end else if (r_phase == PH_EMPTY) begin
                        fin = 1'b1; st = ST_BAD_STATE;
                    end else if (cfg.owner != in_caller) begin
                        fin = 1'b1; st = ST_IDENTITY;
                    end else if (r_phase == PH_POISONED) begin
                        fin = 1'b1; st = ST_POISONED;
                    end else if (r_phase != need) begin
                        fin = 1'b1; st = ST_BAD_STATE;
                    end else if (in_op == OP_QUIESCE) begin
                        n_drain = '0;
                        dodrain = 1'b1;
                    end else if (in_op == OP_ABORT || in_op == OP_RETIRE) begin
                        dowrite = 1'b1; wval = r_orig;
                    end else begin
                        dowrite = 1'b1; wval = r_active;
                    end
                end
            end
        end else if (r_step != S_IDLE) begin
            emit_ok = 1'b1;
            if (bst != ST_OK) begin
                fl = 1'b1; fst = bst;
            end else begin
                case (r_step)
                    S_DRAIN_STAT: begin
                        if (!d[0]) begin
                            if (r_pend == OP_PREPARE) dostable = 1'b1;
                            else begin
                                dowrite = 1'b1; wval = r_staged;
                            end
                        end else begin
                            k = K_READ; p = cfg.data_addr; n_step = S_DRAIN_DATA;
                        end
                    end
                    S_DRAIN_DATA: begin
                        n_drain = r_drain + 9'd1;
                        if (n_drain >= cfg.drain_cap) begin
                            fl = 1'b1; fst = ST_EXHAUSTED;
                        end else begin
                            k = K_READ; p = cfg.stat_addr; n_step = S_DRAIN_STAT;
                        end
                    end
                    S_W_WIN1, S_W_WIN2, S_RD_WIN, S_VF_WIN: begin
                        if (d[1]) begin
                            pc = r_poll + 16'd1; n_poll = pc;
                            winpoll = 1'b1; wstep = r_step;
                        end else if (r_step == S_W_WIN1) begin
                            k = K_WRITE; p = cfg.stat_addr; wb = CMD_WRITE_BYTE;
                            n_step = S_W_CMD;
                        end else if (r_step == S_W_WIN2) begin
                            k = K_WRITE; p = cfg.data_addr; wb = r_target;
                            n_step = S_W_DATA;
                        end else begin
                            k = K_WRITE; p = cfg.stat_addr; wb = CMD_READ_BYTE;
                            n_step = vf ? S_VF_CMD : S_RD_CMD;
                        end
                    end
                    S_W_CMD: begin
                        n_mut = 1'b1;
                        pc = '0; n_poll = '0;
                        winpoll = 1'b1; wstep = S_W_WIN2;
                    end
                    S_W_DATA: begin
                        dostable = 1'b1;
                    end
                    S_RD_CMD, S_VF_CMD: begin
                        pc = '0; n_poll = '0; outpoll = 1'b1;
                    end
                    S_RD_OUT, S_VF_OUT: begin
                        if (!d[0]) begin
                            pc = r_poll + 16'd1; n_poll = pc; outpoll = 1'b1;
                        end else if (d[7:5] != 3'd0) begin
                            fl = 1'b1; fst = ST_IO;
                        end else begin
                            k = K_READ; p = cfg.data_addr;
                            n_step = vf ? S_VF_DATA : S_RD_DATA;
                        end
                    end
                    S_RD_DATA, S_VF_DATA: begin
                        if (r_att != 4'd0 && d == r_prev) begin
                            if (vf) begin
                                if (d == r_target) begin
                                    fin = 1'b1; st = ST_OK;
                                    case (r_pend)
                                        OP_PREPARE: n_phase = PH_PREPARED;
                                        OP_QUIESCE: n_phase = PH_QUIESCED;
                                        OP_ABORT, OP_RETIRE: begin
                                            n_phase = PH_EMPTY; n_orig = '0;
                                            n_staged = '0; n_active = '0; n_mut = 1'b0;
                                        end
                                        default: n_phase = PH_ACTIVE;
                                    endcase
                                end else begin
                                    fl = 1'b1; fst = ST_IO;
                                end
                            end else begin
                                sb = (d | 8'h30) & 8'hFC;
                                n_orig = d; n_staged = sb;
                                n_active = (sb & 8'hEF) | 8'h01;
                                dowrite = 1'b1; wval = sb;
                            end
                        end else begin
                            n_prev = d;
                            n_att = r_att + 4'd1;
                            stnext = 1'b1;
                        end
                    end
                    default: begin
                        fl = 1'b1; fst = ST_IO;
                    end
                endcase
            end
        end

        // shared tails, each a short compare chain
        if (dodrain) begin
            if (n_drain >= cfg.drain_cap) begin
                fl = 1'b1; fst = ST_EXHAUSTED;
            end else begin
                k = K_READ; p = cfg.stat_addr; n_step = S_DRAIN_STAT;
            end
        end
        if (dostable) begin
            n_att = '0; n_prev = '0; stnext = 1'b1;
            n_step = (r_step == S_W_DATA) ? S_VF_WIN : S_RD_WIN;
        end
        if (stnext) begin
            if (n_att >= cfg.stable_attempts) begin
                fl = 1'b1; fst = ST_UNAVAIL;
            end else begin
                pc = '0; n_poll = '0; winpoll = 1'b1;
                wstep = (vf || r_step == S_W_DATA) ? S_VF_WIN : S_RD_WIN;
            end
        end
        if (dowrite) begin
            n_inw = 1'b1; n_target = wval;
            pc = '0; n_poll = '0; winpoll = 1'b1; wstep = S_W_WIN1;
        end
        if (winpoll || outpoll) begin
            if (pc >= cfg.poll_cap) begin
                fl = 1'b1; fst = ST_TIMEOUT;
            end else begin
                k = K_READ; p = cfg.stat_addr;
                n_step = winpoll ? wstep : (vf ? S_VF_OUT : S_RD_OUT);
            end
        end
        if (fl) begin
            fin = 1'b1;
            if (n_inw) begin
                n_phase = PH_POISONED; st = ST_POISONED;
            end else begin
                st = fst;
                if (n_pend == OP_PREPARE) begin
                    n_phase = PH_EMPTY; n_orig = '0; n_staged = '0;
                    n_active = '0; n_mut = 1'b0;
                end
            end
        end
        if (fin) begin
            n_step = S_IDLE; k = K_FINISH; p = '0; wb = '0;
        end else begin
            st = ST_OK;
        end
        res.kind = k; res.port = p; res.wbyte = wb; res.status = st;
        res.phase = n_phase; res.mutated = n_mut;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE; r_phase <= PH_EMPTY; r_orig <= '0; r_staged <= '0;
            r_active <= '0; r_mut <= 1'b0; r_gen <= '0; r_poll <= '0;
            r_drain <= '0; r_att <= '0; r_prev <= '0; r_target <= '0;
            r_pend <= '0; r_inw <= 1'b0;
        end else if (accept) begin
            r_step <= n_step; r_phase <= n_phase; r_orig <= n_orig;
            r_staged <= n_staged; r_active <= n_active; r_mut <= n_mut;
            r_gen <= n_gen; r_poll <= n_poll; r_drain <= n_drain; r_att <= n_att;
            r_prev <= n_prev; r_target <= n_target; r_pend <= n_pend; r_inw <= n_inw;
        end
    end

    logic new_item;
    assign new_item = accept && emit_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || m_axis_tready) begin
                r_ov <= r_sv || new_item;
            end
            if (r_ov && !m_axis_tready && new_item) r_sv <= 1'b1;
            else if (m_axis_tready) r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || m_axis_tready) begin
            r_ob <= r_sv ? r_sb : res;
        end
        if (r_ov && !m_axis_tready && new_item) r_sb <= res;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_ob.mutated, r_ob.phase, r_ob.status, r_ob.wbyte,
                            r_ob.port, r_ob.kind};

    a_skid_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid holds an item while output is empty");
    a_no_accept_when_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> !s_axis_tready) else $error("input taken with skid full");
    a_idle_means_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_item && n_step == S_IDLE) |-> (res.kind == K_FINISH))
        else $error("sequence ended without a finish result");

endmodule

// ===== dv/kbc_command_byte_sequencer_tb.sv =====
// testbench for the kbc command byte sequencer: drives requests and bus completions,
// predicts every result with an in-bench sequencer model and checks it field by field
// depends on kbc_pkg and the sequencer rtl
`timescale 1ns / 1ps

module kbc_command_byte_sequencer_tb;
    import kbc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [2:0] op_code, [34:3] caller_identity, [42:35] bus_data, [44:43] bus_result
    logic [47:0] s_axis_tdata;
    // [0] req_type
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [1:0] out_kind, [17:2] port_addr, [25:18] write_byte, [29:26] op_status,
    // [32:30] phase_now, [33] mutated_flag
    logic [39:0] m_axis_tdata;

    kbc_command_byte_sequencer DUT (.*);

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] cfg_owner;
    logic [15:0] cfg_poll, cfg_data_addr, cfg_stat_addr;
    logic [8:0]  cfg_drain;
    logic [3:0]  cfg_stable;
    logic [2:0]  phase, pend_op;
    logic [7:0]  orig_b, staged_b, active_b, prev_b, target_b;
    logic        mutated, writing;
    logic [63:0] gen;
    t_step       step;
    logic [15:0] polls;
    logic [8:0]  drains;
    logic [3:0]  attempts;
    t_result     res_now;

    t_result     expected_results[$];
    int          mismatches;
    int          fail_count;
    int          cycle_count;
    int          sent_count;
    int          hold_cnt;
    bit          stall_on;
    logic [7:0]  last_rd;       // last command byte the model device returned

    task automatic emit_access(logic [1:0] k, logic [15:0] p, logic [7:0] b, t_step s);
        step = s;
        res_now = '{kind: k, port: p, wbyte: b, status: ST_OK, phase: 3'd0, mutated: 1'b0};
    endtask

    task automatic finish_op(logic [3:0] st);
        step = S_IDLE;
        res_now = '{kind: K_FINISH, port: 16'd0, wbyte: 8'd0, status: st, phase: 3'd0,
                    mutated: 1'b0};
    endtask

    task automatic clear_life();
        phase = PH_EMPTY;
        orig_b = 8'd0; staged_b = 8'd0; active_b = 8'd0; mutated = 1'b0;
    endtask

    task automatic fail_op(logic [3:0] st);
        if (writing) begin
            phase = PH_POISONED;
            finish_op(ST_POISONED);
        end else begin
            if (pend_op == OP_PREPARE) clear_life();
            finish_op(st);
        end
    endtask

    task automatic poll_input_free(t_step s);
        if (polls >= cfg_poll) fail_op(ST_TIMEOUT);
        else emit_access(K_READ, cfg_stat_addr, 8'd0, s);
    endtask

    task automatic stable_next(logic vf);
        if (attempts >= cfg_stable) fail_op(ST_UNAVAIL);
        else begin
            polls = 16'd0;
            poll_input_free(vf ? S_VF_WIN : S_RD_WIN);
        end
    endtask

    task automatic start_stable(logic vf);
        attempts = 4'd0;
        prev_b = 8'd0;
        stable_next(vf);
    endtask

    task automatic start_write(logic [7:0] v);
        writing = 1'b1;
        target_b = v;
        polls = 16'd0;
        poll_input_free(S_W_WIN1);
    endtask

    task automatic drain_poll();
        if ({7'd0, drains} >= {7'd0, cfg_drain}) fail_op(ST_EXHAUSTED);
        else emit_access(K_READ, cfg_stat_addr, 8'd0, S_DRAIN_STAT);
    endtask

    task automatic on_completion(logic [7:0] d, logic [1:0] br);
        logic vf;
        t_step s;
        s = step;
        vf = (s >= S_VF_WIN);
        if (br != 2'd0) begin
            fail_op(br == 2'd2 ? ST_UNAVAIL : ST_IO);
            return;
        end
        case (s)
            S_DRAIN_STAT: begin
                if (!d[0]) begin
                    if (pend_op == OP_PREPARE) start_stable(1'b0);
                    else start_write(staged_b);
                end else emit_access(K_READ, cfg_data_addr, 8'd0, S_DRAIN_DATA);
            end
            S_DRAIN_DATA: begin
                drains = drains + 9'd1;
                drain_poll();
            end
            S_W_WIN1, S_W_WIN2, S_RD_WIN, S_VF_WIN: begin
                if (d[1]) begin
                    polls = polls + 16'd1;
                    poll_input_free(s);
                end else if (s == S_W_WIN1) emit_access(K_WRITE, cfg_stat_addr,
                                                         CMD_WRITE_BYTE, S_W_CMD);
                else if (s == S_W_WIN2) emit_access(K_WRITE, cfg_data_addr, target_b, S_W_DATA);
                else emit_access(K_WRITE, cfg_stat_addr, CMD_READ_BYTE,
                                 vf ? S_VF_CMD : S_RD_CMD);
            end
            S_W_CMD: begin
                mutated = 1'b1;
                polls = 16'd0;
                poll_input_free(S_W_WIN2);
            end
            S_W_DATA: start_stable(1'b1);
            S_RD_CMD, S_VF_CMD: begin
                polls = 16'd0;
                if (polls >= cfg_poll) fail_op(ST_TIMEOUT);
                else emit_access(K_READ, cfg_stat_addr, 8'd0, vf ? S_VF_OUT : S_RD_OUT);
            end
            S_RD_OUT, S_VF_OUT: begin
                if (!d[0]) begin
                    polls = polls + 16'd1;
                    if (polls >= cfg_poll) fail_op(ST_TIMEOUT);
                    else emit_access(K_READ, cfg_stat_addr, 8'd0, s);
                end else if ((d & 8'hE0) != 8'd0) fail_op(ST_IO);
                else emit_access(K_READ, cfg_data_addr, 8'd0, vf ? S_VF_DATA : S_RD_DATA);
            end
            default: begin
                if (attempts != 4'd0 && d == prev_b) begin
                    if (vf) begin
                        if (d == target_b) begin
                            if (pend_op == OP_PREPARE) phase = PH_PREPARED;
                            else if (pend_op == OP_QUIESCE) phase = PH_QUIESCED;
                            else if (pend_op == OP_ABORT || pend_op == OP_RETIRE) clear_life();
                            else phase = PH_ACTIVE;
                            finish_op(ST_OK);
                        end else fail_op(ST_IO);
                    end else begin
                        orig_b = d;
                        staged_b = (d | 8'h30) & 8'hFC;
                        active_b = (staged_b & 8'hEF) | 8'h01;
                        start_write(staged_b);
                    end
                end else begin
                    prev_b = d;
                    attempts = attempts + 4'd1;
                    stable_next(vf);
                end
            end
        endcase
    endtask

    task automatic on_request(logic [2:0] op, logic [31:0] caller);
        logic [2:0] need;
        pend_op = op;
        writing = 1'b0;
        if (op > OP_RETIRE) begin
            finish_op(ST_BAD_ARG);
        end else if (op == OP_PREPARE) begin
            if (cfg_owner == 32'd0 || cfg_owner == '1 || cfg_poll == 16'd0 ||
                cfg_drain == 9'd0 || cfg_drain > 9'(DRAIN_LIMIT_MAX) || cfg_stable < 4'd2 ||
                cfg_stable > 4'(STABLE_ATTEMPTS_MAX) || cfg_data_addr == 16'd0 ||
                cfg_stat_addr == 16'd0 || cfg_data_addr == cfg_stat_addr)
                finish_op(ST_BAD_ARG);
            else if (phase == PH_POISONED) finish_op(ST_POISONED);
            else if (phase != PH_EMPTY) finish_op(ST_BAD_STATE);
            else if (gen >= GEN_LIMIT) finish_op(ST_EXHAUSTED);
            else begin
                gen = gen + 64'd1;
                drains = 9'd0;
                drain_poll();
            end
        end else if (caller == 32'd0 || caller == '1) finish_op(ST_BAD_ARG);
        else if (phase == PH_EMPTY) finish_op(ST_BAD_STATE);
        else if (cfg_owner != caller) finish_op(ST_IDENTITY);
        else if (phase == PH_POISONED) finish_op(ST_POISONED);
        else begin
            need = (op == OP_PUBLISH || op == OP_ABORT) ? PH_PREPARED :
                   (op == OP_QUIESCE ? PH_ACTIVE : PH_QUIESCED);
            if (phase != need) finish_op(ST_BAD_STATE);
            else if (op == OP_QUIESCE) begin
                drains = 9'd0;
                drain_poll();
            end else if (op == OP_ABORT || op == OP_RETIRE) start_write(orig_b);
            else start_write(active_b);
        end
    endtask

    // one accepted item through the predictor
    task automatic predict_item(logic is_cpl, logic [47:0] d);
        if (!is_cpl) begin
            if (step != S_IDLE) return;
            on_request(d[2:0], d[34:3]);
        end else begin
            if (step == S_IDLE) return;
            on_completion(d[42:35], d[44:43]);
        end
        res_now.phase = phase;
        res_now.mutated = mutated;
        expected_results.push_back(res_now);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_OWNER:  cfg_owner = v;
            CFG_POLL:   cfg_poll = v[15:0];
            CFG_DRAIN:  cfg_drain = v[8:0];
            CFG_STABLE: cfg_stable = v[3:0];
            CFG_DATA:   cfg_data_addr = v[15:0];
            default:    cfg_stat_addr = v[15:0];
        endcase
    endtask

    task automatic set_cfg(logic [31:0] own, logic [15:0] pl, logic [8:0] dl, logic [3:0] sa,
                           logic [15:0] dp, logic [15:0] sp);
        wait_idle();
        write_reg(CFG_OWNER, own);
        write_reg(CFG_POLL, {16'd0, pl});
        write_reg(CFG_DRAIN, {23'd0, dl});
        write_reg(CFG_STABLE, {28'd0, sa});
        write_reg(CFG_DATA, {16'd0, dp});
        write_reg(CFG_STATUS, {16'd0, sp});
    endtask

    // send one item, with a random gap first now and then
    task automatic send_item(logic is_cpl, logic [47:0] d);
        if (hold_cnt == 0) begin
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
            hold_cnt = $urandom_range(1, 12);
        end
        hold_cnt--;
        s_axis_tvalid = 1'b1; s_axis_tuser = is_cpl; s_axis_tdata = d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(is_cpl, d);
        sent_count++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_req(logic [2:0] op, logic [31:0] id);
        send_item(1'b0, {3'd0, 2'd0, 8'd0, id, op});
    endtask

    task automatic send_cpl(logic [7:0] d, logic [1:0] br);
        send_item(1'b1, {3'd0, br, d, 32'($urandom), 3'($urandom)});
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // answer the outstanding access the way a mostly sane controller would
    task automatic answer_access(int err_pct);
        logic [1:0] br;
        logic [7:0] d;
        br = ($urandom_range(0, 99) < err_pct) ? 2'($urandom_range(1, 3)) : 2'd0;
        case (step)
            S_DRAIN_STAT: d = {7'($urandom), ($urandom_range(0, 3) == 0)};
            S_W_WIN1, S_W_WIN2, S_RD_WIN, S_VF_WIN:
                d = {6'($urandom), ($urandom_range(0, 3) == 0), 1'($urandom)};
            S_RD_OUT, S_VF_OUT:
                d = {($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'd0, 4'($urandom),
                     ($urandom_range(0, 3) != 0)};
            S_RD_DATA: d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : last_rd;
            S_VF_DATA: d = ($urandom_range(0, 7) == 0) ? 8'($urandom) : target_b;
            default:   d = 8'($urandom);
        endcase
        if (step == S_RD_DATA) last_rd = d;
        send_cpl(d, br);
    endtask

    // run one request and its whole bus sequence
    task automatic run_op(logic [2:0] op, logic [31:0] id, int err_pct);
        send_req(op, id);
        while (step != S_IDLE) answer_access(err_pct);
    endtask

    task automatic test_directed();
        set_cfg(32'h1234_5678, 16'd4, 9'd256, 4'd8, 16'h0060, 16'h0064);
        send_cpl(8'hFF, 2'd0);                  // completion while idle
        send_req(3'd6, 32'h1234_5678);          // unknown op codes
        send_req(3'd7, 32'hFFFF_FFFF);
        send_req(OP_PUBLISH, 32'h1234_5678);    // bad state while empty
        send_req(OP_PUBLISH, 32'h0);            // invalid caller
        run_op(OP_PREPARE, 32'h0, 0);
        send_req(OP_PUBLISH, 32'h1111_1111);    // identity mismatch
        send_req(OP_PREPARE, 32'h0);            // already prepared
        run_op(OP_PUBLISH, 32'h1234_5678, 0);
        run_op(OP_QUIESCE, 32'h1234_5678, 0);
        run_op(OP_RESUME, 32'h1234_5678, 0);
        run_op(OP_QUIESCE, 32'h1234_5678, 0);
        run_op(OP_RETIRE, 32'h1234_5678, 0);
        // request while busy is dropped
        send_req(OP_PREPARE, 32'h0);
        send_req(OP_ABORT, 32'h1234_5678);
        while (step != S_IDLE) answer_access(0);
    endtask

    task automatic test_bad_config();
        set_cfg(32'hFFFF_FFFF, 16'd1, 9'd1, 4'd2, 16'h0001, 16'hFFFF);
        send_req(OP_PREPARE, 32'h0);
        set_cfg(32'h0000_0001, 16'd0, 9'd0, 4'd0, 16'h0000, 16'h0000);
        send_req(OP_PREPARE, 32'h0);
        set_cfg(32'h0000_0001, 16'hFFFF, 9'h1FF, 4'hF, 16'h0060, 16'h0060);
        send_req(OP_PREPARE, 32'h0);
        // tight limits: timeouts, exhausted drains and poisoning show up quickly
        set_cfg(32'hFFFF_FFFE, 16'd1, 9'd1, 4'd2, 16'hFFFF, 16'h0001);
        repeat (12) begin
            run_op(OP_PREPARE, 32'h0, 10);
            run_op(3'($urandom_range(1, 5)), 32'hFFFF_FFFE, 10);
            run_op(OP_ABORT, 32'hFFFF_FFFE, 10);
        end
    endtask

    task automatic test_random(int target);
        int kind;
        logic [31:0] id;
        while (sent_count < target) begin
            if ($urandom_range(0, 199) == 0)
                set_cfg(32'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
                        9'($urandom_range(1, 4)), 4'($urandom_range(2, 8)),
                        16'($urandom_range(1, 32767)), 16'($urandom_range(32768, 65535)));
            kind = $urandom_range(0, 19);
            id = ($urandom_range(0, 7) == 0) ? 32'($urandom) : cfg_owner;
            if (kind == 0) begin
                send_cpl(8'($urandom), 2'($urandom));   // noise
            end else if (kind == 1) begin
                send_req(3'($urandom), id);
                if (step != S_IDLE) begin
                    repeat ($urandom_range(1, 3)) begin
                        if (step != S_IDLE) answer_access(5);
                    end
                    if ($urandom_range(0, 1)) send_req(3'($urandom), id);  // dropped if a sequence still runs
                    while (step != S_IDLE) answer_access(5);
                end
            end else begin
                case (phase)
                    PH_EMPTY, PH_POISONED: run_op(OP_PREPARE, id, 4);
                    PH_PREPARED: run_op($urandom_range(0, 3) == 0 ? OP_ABORT : OP_PUBLISH,
                                        id, 4);
                    PH_ACTIVE: run_op(OP_QUIESCE, id, 4);
                    default: run_op($urandom_range(0, 1) ? OP_RESUME : OP_RETIRE, id, 4);
                endcase
                // leave poisoned only through reset; keep going with fresh owner traffic
            end
        end
    endtask

    task automatic test_generation_limit();
        // the generation counter cannot be reached in a run; prepare keeps working
        set_cfg(32'h0000_0005, 16'd65535, 9'd256, 4'd8, 16'h0060, 16'h0064);
        run_op(OP_PREPARE, 32'h0, 0);
        run_op(OP_ABORT, 32'h0000_0005, 0);
    endtask

    // checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind    = m_axis_tdata[1:0];
            got.port    = m_axis_tdata[17:2];
            got.wbyte   = m_axis_tdata[25:18];
            got.status  = m_axis_tdata[29:26];
            got.phase   = m_axis_tdata[32:30];
            got.mutated = m_axis_tdata[33];
            if (expected_results.size() == 0) begin
                fail_count++;
                if (mismatches < 10) $display("unexpected result %h", got);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (mismatches < 10)
                        $display({"mismatch: kind %0d/%0d port %h/%h byte %h/%h",
                                  " st %0d/%0d ph %0d/%0d mut %0d/%0d"},
                                 want.kind, got.kind, want.port, got.port,
                                 want.wbyte, got.wbyte, want.status, got.status,
                                 want.phase, got.phase, want.mutated, got.mutated);
                    mismatches++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        cycle_count++;
        if (cycle_count > 1000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if ($urandom_range(0, 31) == 0) stall_on = !stall_on;
        m_axis_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        stall_on = 1'b0; hold_cnt = 0; mismatches = 0; fail_count = 0; cycle_count = 0;
        sent_count = 0;
        cfg_owner = '0; cfg_poll = '0; cfg_drain = '0; cfg_stable = '0;
        cfg_data_addr = '0; cfg_stat_addr = '0;
        phase = PH_EMPTY; pend_op = OP_PREPARE; orig_b = '0; staged_b = '0; active_b = '0;
        prev_b = '0; target_b = '0; mutated = 1'b0; writing = 1'b0; gen = '0;
        step = S_IDLE; polls = '0; drains = '0; attempts = '0; last_rd = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_bad_config();
        test_generation_limit();
        set_cfg(32'h0000_0002, 16'd3, 9'd3, 4'd4, 16'h0060, 16'h0064);
        test_random(1050);
        wait_idle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
